[sv/kissd_pkg.sv]
// Shared types and constants for the KISS stream deframer.
// Used by kissd_front, kissd_back and kiss_stream_deframer; no dependencies.
package kissd_pkg;

    localparam logic [7:0] FEND   = 8'hC0;
    localparam logic [7:0] FESC   = 8'hDB;
    localparam logic [7:0] TFEND  = 8'hDC;
    localparam logic [7:0] TFESC  = 8'hDD;

    // Queue between front and back
    localparam int unsigned FQ_DEPTH = 4;
    localparam int unsigned FQ_PTR_W = 2;
    localparam int unsigned FQ_CNT_W = 3;

    // Result queue
    localparam int unsigned OQ_DEPTH = 2;
    localparam int unsigned OQ_PTR_W = 1;
    localparam int unsigned OQ_CNT_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_CMD  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    // One raw byte with its class, as handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_fend;
        logic       is_fesc;
        logic       is_tfend;
        logic       is_tfesc;
    } t_class_beat;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

endpackage

[sv/kiss_stream_deframer.sv]
// Top level of the KISS stream deframer: front classifier queue and back frame
// engine. Depends on kissd_pkg, kissd_front and kissd_back.
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+-------------------------------
//  input    | in        | push / full            | i_rx_byte
//  result   | out       | empty / pop            | o_frame_byte, o_frame_end
//  config   | in        | i_cfg_wr_en            | i_cfg_wr_data (accepted command)
//
// One raw byte per cycle is taken while full is low; each result passes through
// the front queue, then the result queue. The rate is set by the back engine,
// which retires one queued byte per cycle while the two-entry result queue has
// room. A stalled pop fills the result queue, then the four-entry front queue,
// then raises full. Reset is synchronous: both queues empty, the engine hunts
// for an opening delimiter, accepted command is zero.
module kiss_stream_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end
);

    logic                   w_beat_valid;
    logic                   w_beat_ready;
    kissd_pkg::t_class_beat w_beat;

    kissd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .o_beat_valid (w_beat_valid),
        .o_beat       (w_beat),
        .i_beat_ready (w_beat_ready)
    );

    kissd_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_beat_valid  (w_beat_valid),
        .i_beat        (w_beat),
        .o_beat_ready  (w_beat_ready),
        .empty         (empty),
        .pop           (pop),
        .o_frame_byte  (o_frame_byte),
        .o_frame_end   (o_frame_end)
    );

endmodule

[sv/kissd_front.sv]
// Front part of the KISS deframer: accepts raw bytes, classifies them and
// queues them for the back part. Depends on kissd_pkg.
module kissd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_beat_valid,
    output kissd_pkg::t_class_beat o_beat,
    input  logic                   i_beat_ready
);

    kissd_pkg::t_class_beat r_mem [kissd_pkg::FQ_DEPTH];
    logic [kissd_pkg::FQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [kissd_pkg::FQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [kissd_pkg::FQ_CNT_W-1:0] r_count,  n_count;
    kissd_pkg::t_class_beat w_class;
    logic w_wr, w_rd;

    always_comb begin
        w_class.data     = i_rx_byte;
        w_class.is_fend  = (i_rx_byte == kissd_pkg::FEND);
        w_class.is_fesc  = (i_rx_byte == kissd_pkg::FESC);
        w_class.is_tfend = (i_rx_byte == kissd_pkg::TFEND);
        w_class.is_tfesc = (i_rx_byte == kissd_pkg::TFESC);
    end

    assign full         = (r_count == kissd_pkg::FQ_CNT_W'(kissd_pkg::FQ_DEPTH));
    assign o_beat_valid = (r_count != '0);
    assign o_beat       = r_mem[r_rd_ptr];
    assign w_wr         = push && !full;
    assign w_rd         = o_beat_valid && i_beat_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + kissd_pkg::FQ_PTR_W'(1);
        n_rd_ptr = r_rd_ptr + kissd_pkg::FQ_PTR_W'(1);
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + kissd_pkg::FQ_CNT_W'(1);
        end else if (!w_wr && w_rd) begin
            n_count = r_count - kissd_pkg::FQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kissd_pkg::FQ_CNT_W'(kissd_pkg::FQ_DEPTH))
        else $error("front queue count overflow");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[kissd_pkg::FQ_PTR_W-1:0])
        else $error("front queue pointers disagree with count");

endmodule

[sv/kissd_back.sv]
// Back part of the KISS deframer: runs the frame state machine on classified
// bytes, unescapes, holds one byte back and queues results. Depends on kissd_pkg.
module kissd_back #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [7:0]             i_cfg_wr_data,
    input  logic                   i_beat_valid,
    input  kissd_pkg::t_class_beat i_beat,
    output logic                   o_beat_ready,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             o_frame_byte,
    output logic                   o_frame_end
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    kissd_pkg::t_phase r_phase, n_phase;
    logic             r_esc, n_esc;
    logic             r_match, n_match;
    logic [7:0]       r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_accepted_command;

    kissd_pkg::t_out_beat r_oq [kissd_pkg::OQ_DEPTH];
    logic [kissd_pkg::OQ_PTR_W-1:0] r_oq_wr, r_oq_rd;
    logic [kissd_pkg::OQ_CNT_W-1:0] r_oq_count, n_oq_count;

    logic w_take, w_emit, w_emit_last, w_dec_valid, w_oq_rd;
    logic [7:0] w_dec;

    assign o_beat_ready = (r_oq_count != kissd_pkg::OQ_CNT_W'(kissd_pkg::OQ_DEPTH));
    assign w_take       = i_beat_valid && o_beat_ready;

    always_comb begin
        n_phase      = r_phase;
        n_esc        = r_esc;
        n_match      = r_match;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_cnt        = r_cnt;
        w_emit       = 1'b0;
        w_emit_last  = 1'b0;
        w_dec_valid  = 1'b0;
        w_dec        = i_beat.data;
        case (r_phase)
            kissd_pkg::PH_CMD: begin
                if (i_beat.is_fend) begin
                    n_phase = kissd_pkg::PH_HUNT;
                end else begin
                    n_match      = (i_beat.data == r_accepted_command);
                    n_esc        = 1'b0;
                    n_held_valid = 1'b0;
                    n_cnt        = '0;
                    n_phase      = kissd_pkg::PH_BODY;
                end
            end
            kissd_pkg::PH_BODY: begin
                if (i_beat.is_fend) begin
                    // close frame: flag the held byte as last
                    w_emit       = r_held_valid && r_match;
                    w_emit_last  = 1'b1;
                    n_held_valid = 1'b0;
                    n_esc        = 1'b0;
                    n_phase      = kissd_pkg::PH_HUNT;
                end else if (r_esc) begin
                    n_esc = 1'b0;
                    if (i_beat.is_tfend) begin
                        w_dec_valid = 1'b1;
                        w_dec       = kissd_pkg::FEND;
                    end else if (i_beat.is_tfesc) begin
                        w_dec_valid = 1'b1;
                        w_dec       = kissd_pkg::FESC;
                    end
                end else if (i_beat.is_fesc) begin
                    n_esc = 1'b1;
                end else begin
                    w_dec_valid = 1'b1;
                end
                // drop decoded bytes past the length limit
                if (w_dec_valid && (r_cnt < CNT_W'(MAX_FRAME_BYTES))) begin
                    w_emit       = r_held_valid && r_match;
                    n_held       = w_dec;
                    n_held_valid = 1'b1;
                    n_cnt        = r_cnt + CNT_W'(1);
                end
            end
            default: begin
                n_phase = i_beat.is_fend ? kissd_pkg::PH_CMD : kissd_pkg::PH_HUNT;
            end
        endcase
    end

    assign w_oq_rd = pop && !empty;

    always_comb begin
        n_oq_count = r_oq_count;
        if ((w_take && w_emit) && !w_oq_rd) begin
            n_oq_count = r_oq_count + kissd_pkg::OQ_CNT_W'(1);
        end else if (!(w_take && w_emit) && w_oq_rd) begin
            n_oq_count = r_oq_count - kissd_pkg::OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= kissd_pkg::PH_HUNT;
            r_esc              <= 1'b0;
            r_match            <= 1'b0;
            r_held_valid       <= 1'b0;
            r_cnt              <= '0;
            r_accepted_command <= 8'h00;
            r_oq_wr            <= '0;
            r_oq_rd            <= '0;
            r_oq_count         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_accepted_command <= i_cfg_wr_data;
            end
            if (w_take) begin
                r_phase      <= n_phase;
                r_esc        <= n_esc;
                r_match      <= n_match;
                r_held_valid <= n_held_valid;
                r_cnt        <= n_cnt;
            end
            if (w_take && w_emit) begin
                r_oq_wr <= r_oq_wr + kissd_pkg::OQ_PTR_W'(1);
            end
            if (w_oq_rd) begin
                r_oq_rd <= r_oq_rd + kissd_pkg::OQ_PTR_W'(1);
            end
            r_oq_count <= n_oq_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_held <= n_held;
        end
        if (w_take && w_emit) begin
            r_oq[r_oq_wr] <= '{data: r_held, last: w_emit_last};
        end
    end

    assign empty        = (r_oq_count == '0);
    assign o_frame_byte = r_oq[r_oq_rd].data;
    assign o_frame_end  = r_oq[r_oq_rd].last;

    a_hunt_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == kissd_pkg::PH_HUNT) |-> !r_held_valid)
        else $error("held byte valid while hunting");

    a_close_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (r_phase == kissd_pkg::PH_BODY) && i_beat.is_fend)
        |=> (r_phase == kissd_pkg::PH_HUNT) && !r_esc)
        else $error("closing delimiter did not end the frame");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_count <= kissd_pkg::OQ_CNT_W'(kissd_pkg::OQ_DEPTH))
        else $error("result queue overflow");

endmodule
